// File: hw/rtl/obb_pkg.sv
// Shared constants, command codes and word types for the orthonormal basis builder.
// No dependencies.
`default_nettype none

package obb_pkg;

  localparam int UNIT_W   = 16;   // Q1.14 component
  localparam int FRAC     = 14;
  localparam int QUO_W    = 15;   // normalized magnitude, at most 16384
  localparam int ONE_Q14  = 16384;
  localparam int THR_W    = 15;
  localparam logic [THR_W-1:0] THR_RESET = 15'd164;
  localparam int CROSS_W  = 31;   // cross of two Q1.14 units, Q2.28 with sign

  localparam int CMD_BITS = 4;
  localparam logic [CMD_BITS-1:0] CMD_U  = 4'd0;
  localparam logic [CMD_BITS-1:0] CMD_V  = 4'd1;
  localparam logic [CMD_BITS-1:0] CMD_W  = 4'd2;
  localparam logic [CMD_BITS-1:0] CMD_UV = 4'd3;
  localparam logic [CMD_BITS-1:0] CMD_VU = 4'd4;
  localparam logic [CMD_BITS-1:0] CMD_UW = 4'd5;
  localparam logic [CMD_BITS-1:0] CMD_WU = 4'd6;
  localparam logic [CMD_BITS-1:0] CMD_VW = 4'd7;
  localparam logic [CMD_BITS-1:0] CMD_WV = 4'd8;

  typedef logic signed [UNIT_W-1:0] unit_t;

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    logic                bad;
    unit_t               ax;
    unit_t               ay;
    unit_t               az;
  } mid_t;

  typedef struct packed {
    unit_t ux;
    unit_t uy;
    unit_t uz;
    unit_t vx;
    unit_t vy;
    unit_t vz;
    unit_t wx;
    unit_t wy;
    unit_t wz;
    logic  degenerate;
  } basis_t;

endpackage

`default_nettype wire

// File: hw/rtl/obb_norm.sv
// Pipelined 3-vector normalizer: sum of squares, bit-per-stage square root,
// bit-per-stage division of each component to Q1.14. Uses obb_pkg.
`default_nettype none

module obb_norm #(
  parameter int IW = 16,
  parameter int TW = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [IW-1:0]               comp_i [3],
  input  logic [TW-1:0]                      tag_i,
  output logic                               valid_o,
  output logic signed [obb_pkg::UNIT_W-1:0]  comp_o [3],
  output logic                               zero_o,
  output logic [TW-1:0]                      tag_o
);

  localparam int RW = IW + 1;
  localparam int SW = 2 * IW + 2;
  localparam int QW = obb_pkg::QUO_W;
  localparam int DW = RW + QW;
  localparam int FR = obb_pkg::FRAC;

  typedef struct packed {
    logic [2:0]      sgn;
    logic [3*IW-1:0] mag;
    logic [TW-1:0]   tag;
  } side_t;

  typedef struct packed {
    logic [2:0]    sgn;
    logic [TW-1:0] tag;
  } dside_t;

  logic            va_q, vb_q, vc_q;
  side_t           sa_d, sa_q, sb_q, sc_q;
  logic [2*IW-1:0] sq_b_q [3];
  logic [SW-1:0]   sum_c_q;

  always_comb begin
    sa_d.tag = tag_i;
    for (int k = 0; k < 3; k++) begin
      sa_d.sgn[k] = comp_i[k][IW-1];
      sa_d.mag[k*IW +: IW] = comp_i[k][IW-1] ? $unsigned(-comp_i[k]) : $unsigned(comp_i[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q <= sa_d;
      sb_q <= sa_q;
      sc_q <= sb_q;
      for (int k = 0; k < 3; k++) begin
        sq_b_q[k] <= sa_q.mag[k*IW +: IW] * sa_q.mag[k*IW +: IW];
      end
      sum_c_q <= SW'(sq_b_q[0]) + SW'(sq_b_q[1]) + SW'(sq_b_q[2]);
    end
  end

  // square root, one result bit per stage, remainder kept as n - root^2
  logic          sv_q    [RW];
  side_t         ss_q    [RW];
  logic [SW-1:0] srem_q  [RW];
  logic [RW-1:0] sroot_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int B = RW - 1 - k;
    logic          pv;
    side_t         ps;
    logic [SW-1:0] prem, trial, rem_d;
    logic [RW-1:0] proot, root_d;
    logic          take;

    if (k == 0) begin : g_first
      assign pv    = vc_q;
      assign ps    = sc_q;
      assign prem  = sum_c_q;
      assign proot = '0;
    end else begin : g_next
      assign pv    = sv_q[k-1];
      assign ps    = ss_q[k-1];
      assign prem  = srem_q[k-1];
      assign proot = sroot_q[k-1];
    end

    assign trial  = (SW'(proot) << (B + 1)) + (SW'(1) << (2 * B));
    assign take   = (prem >= trial);
    assign rem_d  = take ? (prem - trial) : prem;
    assign root_d = proot | (RW'(take) << B);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k] <= 1'b0;
      end else if (en_i) begin
        sv_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ss_q[k]    <= ps;
        srem_q[k]  <= rem_d;
        sroot_q[k] <= root_d;
      end
    end
  end

  // restoring division of (|c| << 14) + len/2 by len, one quotient bit per stage
  logic          dv_q   [QW];
  dside_t        ds_q   [QW];
  logic [RW-1:0] dlen_q [QW];
  logic [DW-1:0] drem_q [QW][3];
  logic [QW-1:0] dquo_q [QW][3];

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic          pv;
    dside_t        ps;
    logic [RW-1:0] plen;
    logic [DW-1:0] prem [3];
    logic [QW-1:0] pquo [3];
    logic [DW-1:0] dvs;
    logic [DW-1:0] rem_d [3];
    logic [QW-1:0] quo_d [3];

    if (j == 0) begin : g_first
      assign pv   = sv_q[RW-1];
      assign ps   = '{sgn: ss_q[RW-1].sgn, tag: ss_q[RW-1].tag};
      assign plen = sroot_q[RW-1];
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          prem[k] = (DW'(ss_q[RW-1].mag[k*IW +: IW]) << FR) + DW'(plen >> 1);
          pquo[k] = '0;
        end
      end
    end else begin : g_next
      assign pv   = dv_q[j-1];
      assign ps   = ds_q[j-1];
      assign plen = dlen_q[j-1];
      assign prem = drem_q[j-1];
      assign pquo = dquo_q[j-1];
    end

    assign dvs = DW'(plen) << B;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        rem_d[k] = (prem[k] >= dvs) ? (prem[k] - dvs) : prem[k];
        quo_d[k] = pquo[k] | (QW'(prem[k] >= dvs) << B);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (en_i) begin
        dv_q[j] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ds_q[j]   <= ps;
        dlen_q[j] <= plen;
        drem_q[j] <= rem_d;
        dquo_q[j] <= quo_d;
      end
    end
  end

  assign valid_o = dv_q[QW-1];
  assign tag_o   = ds_q[QW-1].tag;
  assign zero_o  = (dlen_q[QW-1] == '0);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      comp_o[k] = ds_q[QW-1].sgn[k] ? -$signed({1'b0, dquo_q[QW-1][k]})
                                    :  $signed({1'b0, dquo_q[QW-1][k]});
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/orthonormal_basis_build.sv
// Orthonormal basis builder, top level: threshold register, two input normalizers,
// cross / axis select, cross normalizer, third-axis cross, two-word output skid.
// Throughput: one word per cycle; the whole pipeline advances together and halts
// only while both skid entries are full. Reset clears valids, skid count and sets
// the threshold to 164.
`default_nettype none

module orthonormal_basis_build #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [obb_pkg::THR_W-1:0]            parallel_threshold_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [obb_pkg::CMD_BITS-1:0]         command_i,
  input  logic signed [COMPONENT_BITS-1:0]     first_x_i,
  input  logic signed [COMPONENT_BITS-1:0]     first_y_i,
  input  logic signed [COMPONENT_BITS-1:0]     first_z_i,
  input  logic signed [COMPONENT_BITS-1:0]     second_x_i,
  input  logic signed [COMPONENT_BITS-1:0]     second_y_i,
  input  logic signed [COMPONENT_BITS-1:0]     second_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [obb_pkg::UNIT_W-1:0]    u_x_o,
  output logic signed [obb_pkg::UNIT_W-1:0]    u_y_o,
  output logic signed [obb_pkg::UNIT_W-1:0]    u_z_o,
  output logic signed [obb_pkg::UNIT_W-1:0]    v_x_o,
  output logic signed [obb_pkg::UNIT_W-1:0]    v_y_o,
  output logic signed [obb_pkg::UNIT_W-1:0]    v_z_o,
  output logic signed [obb_pkg::UNIT_W-1:0]    w_x_o,
  output logic signed [obb_pkg::UNIT_W-1:0]    w_y_o,
  output logic signed [obb_pkg::UNIT_W-1:0]    w_z_o,
  output logic                                 degenerate_o
);

  localparam int CW = obb_pkg::CROSS_W;
  localparam int MW = $bits(obb_pkg::mid_t);

  logic                     en;
  logic [obb_pkg::THR_W-1:0] thresh_q;
  logic [1:0]               cnt_q;

  assign en          = (cnt_q != 2'd2);
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= obb_pkg::THR_RESET;
    end else if (cfg_valid_i) begin
      thresh_q <= parallel_threshold_i;
    end
  end

  // ---- input normalizers
  logic signed [COMPONENT_BITS-1:0] f_in [3];
  logic signed [COMPONENT_BITS-1:0] s_in [3];
  obb_pkg::unit_t                   nf [3];
  obb_pkg::unit_t                   ns [3];
  logic                             f_v, s_v, f_zero, s_zero, s_two;
  logic [obb_pkg::CMD_BITS-1:0]     f_cmd;
  logic                             two_in;

  assign f_in[0] = first_x_i;
  assign f_in[1] = first_y_i;
  assign f_in[2] = first_z_i;
  assign s_in[0] = second_x_i;
  assign s_in[1] = second_y_i;
  assign s_in[2] = second_z_i;
  assign two_in  = (command_i >= obb_pkg::CMD_UV);

  obb_norm #(.IW(COMPONENT_BITS), .TW(obb_pkg::CMD_BITS)) u_norm_f (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .comp_i(f_in), .tag_i(command_i),
    .valid_o(f_v), .comp_o(nf), .zero_o(f_zero), .tag_o(f_cmd)
  );

  obb_norm #(.IW(COMPONENT_BITS), .TW(1)) u_norm_s (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .comp_i(s_in), .tag_i(two_in),
    .valid_o(s_v), .comp_o(ns), .zero_o(s_zero), .tag_o(s_two)
  );

  // ---- B1: products for the cross and the x-axis test
  logic                         b1_v_q;
  logic [obb_pkg::CMD_BITS-1:0] b1_cmd_q;
  logic                         b1_bad_q;
  obb_pkg::unit_t               b1_nf_q [3];
  logic signed [31:0]           b1_pr_q [6];
  logic signed [31:0]           b1_sy_q, b1_sz_q;
  logic [2*obb_pkg::THR_W-1:0]  b1_tt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
    end else if (en) begin
      b1_v_q <= f_v && s_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_cmd_q   <= f_cmd;
      b1_bad_q   <= (f_cmd > obb_pkg::CMD_WV) || f_zero || (s_two && s_zero);
      b1_nf_q    <= nf;
      b1_pr_q[0] <= nf[1] * ns[2];
      b1_pr_q[1] <= nf[2] * ns[1];
      b1_pr_q[2] <= nf[2] * ns[0];
      b1_pr_q[3] <= nf[0] * ns[2];
      b1_pr_q[4] <= nf[0] * ns[1];
      b1_pr_q[5] <= nf[1] * ns[0];
      b1_sy_q    <= nf[1] * nf[1];
      b1_sz_q    <= nf[2] * nf[2];
      b1_tt_q    <= thresh_q * thresh_q;
    end
  end

  // ---- B2: vector to normalize
  logic signed [32:0]   b2_dif [3];
  logic signed [CW-1:0] b2_c_d [3];
  logic                 b2_fcs, b2_fall, b2_two;
  logic [31:0]          b2_sum;
  obb_pkg::mid_t        b2_mid_d;
  logic                 b2_v_q;
  logic signed [CW-1:0] b2_c_q [3];
  obb_pkg::mid_t        b2_mid_q;

  always_comb begin
    b2_dif[0] = 33'(b1_pr_q[0]) - 33'(b1_pr_q[1]);
    b2_dif[1] = 33'(b1_pr_q[2]) - 33'(b1_pr_q[3]);
    b2_dif[2] = 33'(b1_pr_q[4]) - 33'(b1_pr_q[5]);
    b2_fcs = (b1_cmd_q == obb_pkg::CMD_UV) || (b1_cmd_q == obb_pkg::CMD_WU) ||
             (b1_cmd_q == obb_pkg::CMD_VW);
    b2_two  = (b1_cmd_q >= obb_pkg::CMD_UV);
    b2_sum  = $unsigned(b1_sy_q) + $unsigned(b1_sz_q);
    b2_fall = (b2_sum < 32'(b1_tt_q));
    for (int k = 0; k < 3; k++) begin
      if (b2_two) begin
        b2_c_d[k] = b2_fcs ? CW'(b2_dif[k]) : CW'(-b2_dif[k]);
      end else begin
        b2_c_d[k] = '0;
      end
    end
    if (!b2_two) begin
      // x-axis cross, or y-axis when too short
      if (b2_fall) begin
        b2_c_d[0] = -(CW'(b1_nf_q[2]));
        b2_c_d[1] = '0;
        b2_c_d[2] = CW'(b1_nf_q[0]);
      end else begin
        b2_c_d[0] = '0;
        b2_c_d[1] = CW'(b1_nf_q[2]);
        b2_c_d[2] = -(CW'(b1_nf_q[1]));
      end
    end
    b2_mid_d.cmd = b1_cmd_q;
    b2_mid_d.bad = b1_bad_q;
    b2_mid_d.ax  = b1_nf_q[0];
    b2_mid_d.ay  = b1_nf_q[1];
    b2_mid_d.az  = b1_nf_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_v_q <= 1'b0;
    end else if (en) begin
      b2_v_q <= b1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b2_c_q   <= b2_c_d;
      b2_mid_q <= b2_mid_d;
    end
  end

  // ---- normalize the crossed vector
  logic           n2_v, p_zero;
  obb_pkg::unit_t np [3];
  logic [MW-1:0]  n2_tag;
  obb_pkg::mid_t  n2_mid;

  obb_norm #(.IW(CW), .TW(MW)) u_norm_c (
    .clk_i, .rst_ni, .en_i(en), .valid_i(b2_v_q), .comp_i(b2_c_q), .tag_i(b2_mid_q),
    .valid_o(n2_v), .comp_o(np), .zero_o(p_zero), .tag_o(n2_tag)
  );

  assign n2_mid = obb_pkg::mid_t'(n2_tag);

  // ---- C1: third-axis products
  logic                         c1_nf_first;
  obb_pkg::unit_t               c1_a [3];
  obb_pkg::unit_t               c1_b [3];
  obb_pkg::unit_t               n2_nf [3];
  logic                         c1_v_q, c1_ok_q;
  logic [obb_pkg::CMD_BITS-1:0] c1_cmd_q;
  obb_pkg::unit_t               c1_nf_q [3];
  obb_pkg::unit_t               c1_p_q [3];
  logic signed [31:0]           c1_pr_q [6];

  assign n2_nf[0] = n2_mid.ax;
  assign n2_nf[1] = n2_mid.ay;
  assign n2_nf[2] = n2_mid.az;

  always_comb begin
    c1_nf_first = (n2_mid.cmd == obb_pkg::CMD_U) || (n2_mid.cmd == obb_pkg::CMD_UW) ||
                  (n2_mid.cmd == obb_pkg::CMD_W) || (n2_mid.cmd == obb_pkg::CMD_WV) ||
                  (n2_mid.cmd == obb_pkg::CMD_VU);
    for (int k = 0; k < 3; k++) begin
      c1_a[k] = c1_nf_first ? n2_nf[k] : np[k];
      c1_b[k] = c1_nf_first ? np[k] : n2_nf[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_v_q <= 1'b0;
    end else if (en) begin
      c1_v_q <= n2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_cmd_q   <= n2_mid.cmd;
      c1_ok_q    <= !n2_mid.bad && !p_zero;
      c1_nf_q    <= n2_nf;
      c1_p_q     <= np;
      c1_pr_q[0] <= c1_a[1] * c1_b[2];
      c1_pr_q[1] <= c1_a[2] * c1_b[1];
      c1_pr_q[2] <= c1_a[2] * c1_b[0];
      c1_pr_q[3] <= c1_a[0] * c1_b[2];
      c1_pr_q[4] <= c1_a[0] * c1_b[1];
      c1_pr_q[5] <= c1_a[1] * c1_b[0];
    end
  end

  // ---- C2: round, clamp, place axes
  logic signed [32:0]         c2_dif [3];
  logic [32:0]                c2_mag [3];
  logic [18:0]                c2_rnd [3];
  logic [obb_pkg::QUO_W-1:0]  c2_q [3];
  obb_pkg::unit_t             t3 [3];
  obb_pkg::basis_t            res_d, res_q;
  logic                       res_v_q;

  always_comb begin
    c2_dif[0] = 33'(c1_pr_q[0]) - 33'(c1_pr_q[1]);
    c2_dif[1] = 33'(c1_pr_q[2]) - 33'(c1_pr_q[3]);
    c2_dif[2] = 33'(c1_pr_q[4]) - 33'(c1_pr_q[5]);
    for (int k = 0; k < 3; k++) begin
      // half away from zero on the magnitude
      c2_mag[k] = c2_dif[k][32] ? $unsigned(-c2_dif[k]) : $unsigned(c2_dif[k]);
      c2_rnd[k] = 19'((c2_mag[k] + 33'd8192) >> obb_pkg::FRAC);
      c2_q[k]   = (c2_rnd[k] > 19'(obb_pkg::ONE_Q14)) ? obb_pkg::QUO_W'(obb_pkg::ONE_Q14)
                                                      : obb_pkg::QUO_W'(c2_rnd[k]);
      t3[k]     = c2_dif[k][32] ? -$signed({1'b0, c2_q[k]}) : $signed({1'b0, c2_q[k]});
    end
    res_d = '0;
    res_d.degenerate = !c1_ok_q;
    if (c1_ok_q) begin
      case (c1_cmd_q)
        obb_pkg::CMD_U, obb_pkg::CMD_UW: begin
          {res_d.ux, res_d.uy, res_d.uz} = {c1_nf_q[0], c1_nf_q[1], c1_nf_q[2]};
          {res_d.vx, res_d.vy, res_d.vz} = {c1_p_q[0], c1_p_q[1], c1_p_q[2]};
          {res_d.wx, res_d.wy, res_d.wz} = {t3[0], t3[1], t3[2]};
        end
        obb_pkg::CMD_V, obb_pkg::CMD_VW: begin
          {res_d.ux, res_d.uy, res_d.uz} = {c1_p_q[0], c1_p_q[1], c1_p_q[2]};
          {res_d.vx, res_d.vy, res_d.vz} = {c1_nf_q[0], c1_nf_q[1], c1_nf_q[2]};
          {res_d.wx, res_d.wy, res_d.wz} = {t3[0], t3[1], t3[2]};
        end
        obb_pkg::CMD_W, obb_pkg::CMD_WV: begin
          {res_d.ux, res_d.uy, res_d.uz} = {c1_p_q[0], c1_p_q[1], c1_p_q[2]};
          {res_d.vx, res_d.vy, res_d.vz} = {t3[0], t3[1], t3[2]};
          {res_d.wx, res_d.wy, res_d.wz} = {c1_nf_q[0], c1_nf_q[1], c1_nf_q[2]};
        end
        obb_pkg::CMD_UV: begin
          {res_d.ux, res_d.uy, res_d.uz} = {c1_nf_q[0], c1_nf_q[1], c1_nf_q[2]};
          {res_d.vx, res_d.vy, res_d.vz} = {t3[0], t3[1], t3[2]};
          {res_d.wx, res_d.wy, res_d.wz} = {c1_p_q[0], c1_p_q[1], c1_p_q[2]};
        end
        obb_pkg::CMD_VU: begin
          {res_d.ux, res_d.uy, res_d.uz} = {t3[0], t3[1], t3[2]};
          {res_d.vx, res_d.vy, res_d.vz} = {c1_nf_q[0], c1_nf_q[1], c1_nf_q[2]};
          {res_d.wx, res_d.wy, res_d.wz} = {c1_p_q[0], c1_p_q[1], c1_p_q[2]};
        end
        obb_pkg::CMD_WU: begin
          {res_d.ux, res_d.uy, res_d.uz} = {t3[0], t3[1], t3[2]};
          {res_d.vx, res_d.vy, res_d.vz} = {c1_p_q[0], c1_p_q[1], c1_p_q[2]};
          {res_d.wx, res_d.wy, res_d.wz} = {c1_nf_q[0], c1_nf_q[1], c1_nf_q[2]};
        end
        default: begin
          res_d = '0;
          res_d.degenerate = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (en) begin
      res_v_q <= c1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  // ---- two-word output skid
  logic            push, pop;
  obb_pkg::basis_t sk0_q, sk1_q;

  assign push        = en && res_v_q;
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && ((cnt_q == 2'd0) || (pop && (cnt_q == 2'd1)))) begin
      sk0_q <= res_q;
    end else if (pop) begin
      sk0_q <= sk1_q;
    end
    if (push && !pop && (cnt_q == 2'd1)) begin
      sk1_q <= res_q;
    end
  end

  assign u_x_o        = sk0_q.ux;
  assign u_y_o        = sk0_q.uy;
  assign u_z_o        = sk0_q.uz;
  assign v_x_o        = sk0_q.vx;
  assign v_y_o        = sk0_q.vy;
  assign v_z_o        = sk0_q.vz;
  assign w_x_o        = sk0_q.wx;
  assign w_y_o        = sk0_q.wy;
  assign w_z_o        = sk0_q.wz;
  assign degenerate_o = sk0_q.degenerate;

`ifndef SYNTH
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> (u_x_o == '0) && (u_y_o == '0) && (u_z_o == '0) &&
      (v_x_o == '0) && (v_y_o == '0) && (v_z_o == '0) &&
      (w_x_o == '0) && (w_y_o == '0) && (w_z_o == '0))
    else $error("degenerate word with nonzero components");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (u_x_o <= 16'sd16384) && (u_x_o >= -16'sd16384) &&
      (v_y_o <= 16'sd16384) && (v_y_o >= -16'sd16384) &&
      (w_z_o <= 16'sd16384) && (w_z_o >= -16'sd16384))
    else $error("basis component out of Q1.14 unit range");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push && (cnt_q == 2'd1) |=> !out_valid_o)
    else $error("skid shows a word after its last entry was taken");

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |=> !$past(push) || (cnt_q != 2'd3))
    else $error("skid overflow");
`endif

endmodule

`default_nettype wire

// File: verif/orthonormal_basis_build_tb.sv
// Self-checking testbench for orthonormal_basis_build: a queue-fed driver, a
// bit-exact basis predictor and an output checker. Depends on obb_pkg and the RTL top.
`default_nettype none

module orthonormal_basis_build_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB        = 16;
  localparam int CMD_W     = obb_pkg::CMD_BITS;
  localparam int LATENCY   = CB + 74;
  localparam int WDOG_MAX  = 20000;

  typedef longint vec_t [3];

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic signed [CB-1:0] fx, fy, fz, sx, sy, sz;
  } word_t;

  typedef struct packed {
    obb_pkg::unit_t ux, uy, uz, vx, vy, vz, wx, wy, wz;
    logic  degen;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [obb_pkg::THR_W-1:0] parallel_threshold_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [CMD_W-1:0] command_i = '0;
  logic signed [CB-1:0] first_x_i = '0, first_y_i = '0, first_z_i = '0;
  logic signed [CB-1:0] second_x_i = '0, second_y_i = '0, second_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  obb_pkg::unit_t u_x_o, u_y_o, u_z_o, v_x_o, v_y_o, v_z_o, w_x_o, w_y_o, w_z_o;
  logic degenerate_o;

  orthonormal_basis_build #(.COMPONENT_BITS(CB)) dut (.*);

  initial forever #5 clk_i = ~clk_i;

  word_t  pending_q[$];
  frame_t frame_q[$];
  longint threshold = obb_pkg::THR_RESET;
  int     errors = 0, n_words = 0, n_frames = 0, n_degen = 0;
  bit     hold_in = 1'b0;
  bit     in_fire = 1'b0;

  // ---------------- predictor ----------------
  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned sumsq(vec_t a);
    return mag(a[0]) * mag(a[0]) + mag(a[1]) * mag(a[1]) + mag(a[2]) * mag(a[2]);
  endfunction

  function automatic bit unitize(vec_t a, output vec_t r);
    longint unsigned len = isqrt(sumsq(a));
    longint unsigned q;
    r = '{0, 0, 0};
    if (len == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = (mag(a[i]) * 16384 + len / 2) / len;
      r[i] = a[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic vec_t cross_exact(vec_t a, vec_t b);
    vec_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  // third axis: round half away from zero back to Q1.14, clamp to one
  function automatic vec_t cross_round(vec_t a, vec_t b);
    vec_t w = cross_exact(a, b);
    vec_t r;
    longint unsigned q;
    for (int i = 0; i < 3; i++) begin
      q = (mag(w[i]) + 8192) >> 14;
      if (q > obb_pkg::ONE_Q14) q = obb_pkg::ONE_Q14;
      r[i] = w[i] < 0 ? -longint'(q) : longint'(q);
    end
    return r;
  endfunction

  function automatic frame_t predict_basis(word_t wd, longint thr);
    vec_t f, s, nf, ns, c, p, u, v, w;
    bit ok;
    frame_t fr;
    f = '{wd.fx, wd.fy, wd.fz};
    s = '{wd.sx, wd.sy, wd.sz};
    u = '{0, 0, 0}; v = u; w = u;
    if (wd.cmd > obb_pkg::CMD_WV || !unitize(f, nf)) begin
      ok = 1'b0;
    end else if (wd.cmd <= obb_pkg::CMD_W) begin
      c = '{0, nf[2], -nf[1]};
      if (sumsq(c) < longint'(thr * thr)) c = '{-nf[2], 0, nf[0]};
      ok = unitize(c, p);
      case (wd.cmd)
        obb_pkg::CMD_U: begin u = nf; v = p; w = cross_round(u, v); end
        obb_pkg::CMD_V: begin v = nf; u = p; w = cross_round(u, v); end
        default: begin w = nf; u = p; v = cross_round(w, u); end
      endcase
    end else if (!unitize(s, ns)) begin
      ok = 1'b0;
    end else begin
      if (wd.cmd == obb_pkg::CMD_UV || wd.cmd == obb_pkg::CMD_WU ||
          wd.cmd == obb_pkg::CMD_VW) c = cross_exact(nf, ns);
      else c = cross_exact(ns, nf);
      case (wd.cmd)
        obb_pkg::CMD_UV: begin u = nf; ok = unitize(c, w); v = cross_round(w, u); end
        obb_pkg::CMD_VU: begin v = nf; ok = unitize(c, w); u = cross_round(v, w); end
        obb_pkg::CMD_UW: begin u = nf; ok = unitize(c, v); w = cross_round(u, v); end
        obb_pkg::CMD_WU: begin w = nf; ok = unitize(c, v); u = cross_round(v, w); end
        obb_pkg::CMD_VW: begin v = nf; ok = unitize(c, u); w = cross_round(u, v); end
        default: begin w = nf; ok = unitize(c, u); v = cross_round(w, u); end
      endcase
    end
    if (!ok) return '{degen: 1'b1, default: '0};
    fr.ux = obb_pkg::unit_t'(u[0]);
    fr.uy = obb_pkg::unit_t'(u[1]);
    fr.uz = obb_pkg::unit_t'(u[2]);
    fr.vx = obb_pkg::unit_t'(v[0]);
    fr.vy = obb_pkg::unit_t'(v[1]);
    fr.vz = obb_pkg::unit_t'(v[2]);
    fr.wx = obb_pkg::unit_t'(w[0]);
    fr.wy = obb_pkg::unit_t'(w[1]);
    fr.wz = obb_pkg::unit_t'(w[2]);
    fr.degen = 1'b0;
    return fr;
  endfunction

  // ---------------- driver ----------------
  int gap_left = 0, burst_left = 0;

  always @(negedge clk_i) begin
    word_t wd;
    logic v;
    v = in_valid_i;
    if (!in_valid_i || in_fire) begin
      v = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (!hold_in && pending_q.size() > 0) begin
        wd = pending_q.pop_front();
        v = 1'b1;
        {command_i, first_x_i, first_y_i, first_z_i, second_x_i, second_y_i, second_z_i} <= wd;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
          gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
        end
      end
    end
    in_valid_i <= v;
  end

  // receiver stall pattern with a randomly changing duty
  int cyc = 0;
  int stall_pct = 0;
  always @(negedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc % 256 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    out_ready_i <= $urandom_range(0, 99) >= stall_pct;
  end

  // ---------------- monitor ----------------
  task automatic check_field(string name, logic signed [15:0] want, logic signed [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    frame_t e;
    in_fire <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      frame_q.push_back(predict_basis({command_i, first_x_i, first_y_i, first_z_i,
                                       second_x_i, second_y_i, second_z_i}, threshold));
      n_words++;
    end
    if (out_valid_o && out_ready_i) begin
      n_frames++;
      if (frame_q.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
      end else begin
        e = frame_q.pop_front();
        if (e.degen) n_degen++;
        check_field("u_x", e.ux, u_x_o); check_field("u_y", e.uy, u_y_o);
        check_field("u_z", e.uz, u_z_o); check_field("v_x", e.vx, v_x_o);
        check_field("v_y", e.vy, v_y_o); check_field("v_z", e.vz, v_z_o);
        check_field("w_x", e.wx, w_x_o); check_field("w_y", e.wy, w_y_o);
        check_field("w_z", e.wz, w_z_o);
        check_field("degenerate", 16'(e.degen), 16'(degenerate_o));
      end
    end
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("timeout: no handshake for %0d cycles", WDOG_MAX);
      $display("orthonormal_basis_build_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- stimulus ----------------
  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || frame_q.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [obb_pkg::THR_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    parallel_threshold_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    threshold = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [CB-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      2: return CB'($signed($urandom_range(0, 64)) - 32);
      3: return CB'($signed($urandom_range(0, 1024)) - 512);
      default: return CB'($urandom);
    endcase
  endfunction

  task automatic add(logic [CMD_W-1:0] c, int fx, int fy, int fz, int sx, int sy, int sz);
    pending_q.push_back('{c, CB'(fx), CB'(fy), CB'(fz), CB'(sx), CB'(sy), CB'(sz)});
  endtask

  task automatic add_random(int n);
    word_t wd;
    int k;
    repeat (n) begin
      wd.cmd = $urandom_range(0, 19) == 0 ? CMD_W'($urandom_range(9, 15))
                                          : CMD_W'($urandom_range(0, 8));
      wd.fx = rand_comp(); wd.fy = rand_comp(); wd.fz = rand_comp();
      if ($urandom_range(0, 9) == 0) begin
        // parallel or antiparallel second vector
        k = $urandom_range(0, 1) ? 1 : -1;
        wd.sx = CB'(k * wd.fx); wd.sy = CB'(k * wd.fy); wd.sz = CB'(k * wd.fz);
      end else if ($urandom_range(0, 9) == 0) begin
        // near x axis, exercising the fallback
        wd.fx = CB'($urandom_range(256, 32767)); wd.fy = CB'($urandom_range(0, 3));
        wd.fz = CB'($urandom_range(0, 3));
        wd.sx = rand_comp(); wd.sy = rand_comp(); wd.sz = rand_comp();
      end else begin
        wd.sx = rand_comp(); wd.sy = rand_comp(); wd.sz = rand_comp();
      end
      pending_q.push_back(wd);
    end
  endtask

  initial begin
    logic [obb_pkg::THR_W-1:0] thr_set [6];
    thr_set = '{15'd0, 15'd16384, 15'd16383, 15'd1, 15'($urandom_range(0, 16384)),
                obb_pkg::THR_RESET};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: extremes, every command, zero operands, parallel pairs, x-parallel
    for (int c = 0; c <= 8; c++) add(CMD_W'(c), 256, 512, -768, -1024, 300, 5);
    add(obb_pkg::CMD_U, 32767, 32767, 32767, 0, 0, 0);
    add(obb_pkg::CMD_V, -32768, -32768, -32768, 0, 0, 0);
    add(obb_pkg::CMD_W, 0, 0, 0, 1, 1, 1);
    add(obb_pkg::CMD_UV, 100, 0, 0, 0, 0, 0);
    add(obb_pkg::CMD_WV, 100, 200, 300, 200, 400, 600);
    add(obb_pkg::CMD_VU, 1, 2, 3, -1, -2, -3);
    add(obb_pkg::CMD_U, 32767, 0, 0, 0, 0, 0);
    add(obb_pkg::CMD_V, -32768, 1, 0, 0, 0, 0);
    add(obb_pkg::CMD_W, 256, 0, 1, 0, 0, 0);
    add(obb_pkg::CMD_U, 0, 256, 0, 0, 0, 0);
    add(obb_pkg::CMD_UW, -32768, 32767, 1, 32767, -32768, -1);
    for (int c = 9; c <= 15; c++) add(CMD_W'(c), 256, 256, 256, 256, 0, 0);
    drain();

    add_random(400);
    // one pause: hold the sender until every result is back
    while (pending_q.size() > 200) @(posedge clk_i);
    hold_in = 1'b1;
    while (in_valid_i || frame_q.size() > 0) @(posedge clk_i);
    hold_in = 1'b0;
    drain();

    foreach (thr_set[i]) begin
      write_threshold(thr_set[i]);
      add(obb_pkg::CMD_U, 32767, 40, 40, 0, 0, 0);
      add(obb_pkg::CMD_W, 0, 32767, 0, 0, 0, 0);
      add_random(210);
      drain();
    end

    $display("%0d words sent, %0d results checked (%0d degenerate), 6 threshold settings",
             n_words, n_frames, n_degen);
    if (errors == 0 && frame_q.size() == 0) begin
      $display("orthonormal_basis_build_tb OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, frame_q.size());
      $display("orthonormal_basis_build_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
